// ===== src/lcgsrc_pkg.sv =====
package lcgsrc_pkg;

    localparam int WORD_W = 32;
    localparam int COUNT_W = 7;
    localparam int ADV_CNT_W = 5;

    // generator constants
    localparam logic [WORD_W-1:0] LCG_MUL = 32'd1664525;
    localparam logic [WORD_W-1:0] LCG_ADD = 32'd1013904223;
    localparam logic [WORD_W-1:0] SEED_AT_RESET = 32'd12345;
    localparam int RESEED_PERIOD = 17;
    localparam int MAX_RUN = 64;

    // operation codes; codes 5..7 are ignored
    typedef enum logic [2:0] {
        OP_WORD  = 3'd0,
        OP_BYTES = 3'd1,
        OP_CHARS = 3'd2,
        OP_LOAD  = 3'd3,
        OP_XOR   = 3'd4
    } op_t;

    // command to the generator unit
    typedef struct packed {
        logic              load;
        logic              mix;
        logic              adv;
        logic [WORD_W-1:0] data;
    } gen_cmd_t;

    // 64-symbol alphabet: a..z, 1..9, 0, A..Z, '@', '#'
    function automatic logic [7:0] symbol(input logic [5:0] idx);
        logic [7:0] code;
        logic [7:0] wide;
        wide = {2'b00, idx};
        case (idx) inside
            [6'd0:6'd25]:  code = 8'h61 + wide;
            [6'd26:6'd34]: code = 8'h31 + (wide - 8'd26);
            6'd35:         code = 8'h30;
            [6'd36:6'd61]: code = 8'h41 + (wide - 8'd36);
            6'd62:         code = 8'h40;
            default:       code = 8'h23;
        endcase
        return code;
    endfunction

endpackage

// ===== src/lcgsrc_if.sv =====
// request channel: one operation per beat
interface lcgsrc_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [6:0]  count;
    logic [31:0] seed_value;
    logic [31:0] entropy;

    modport source (output valid, output op, output count, output seed_value,
                    output entropy, input ready);
    modport sink (input valid, input op, input count, input seed_value,
                  input entropy, output ready);
endinterface

// result channel: one word, byte or character per beat
interface lcgsrc_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic        last;

    modport source (output valid, output value, output last, input ready);
    modport sink (input valid, input value, input last, output ready);
endinterface

// ===== src/lcg_random_word_byte_char_source.sv =====
// Random word, byte and character source on a 32-bit linear congruential
// generator. Each request beat carries one operation: emit a word, emit
// count bytes (four per drawn word, leftovers one per word), emit count
// characters (one per drawn word), load the seed or XOR into it. Counts
// saturate at 64; a byte or character count of zero emits nothing. The
// request side is busy while a run is in progress. A request is accepted in
// the idle state; every drawn word is then advanced in the multiply-add unit
// (S_ADV), and every beat is placed in the output register (S_EMIT), which
// waits while the output register holds a beat not yet taken. Seed
// operations end on acceptance. The last beat of each run has last set.
module lcg_random_word_byte_char_source (
    input  logic          clk,
    input  logic          rst_n,
    lcgsrc_req_if.sink    req,
    lcgsrc_rsp_if.source  rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADV,
        S_EMIT
    } state_t;

    state_t                                state_reg;
    state_t                                state_next;
    lcgsrc_pkg::op_t                       op_reg;
    lcgsrc_pkg::op_t                       op_next;
    logic [lcgsrc_pkg::COUNT_W-1:0]        n_reg;
    logic [lcgsrc_pkg::COUNT_W-1:0]        n_next;
    logic [lcgsrc_pkg::COUNT_W-1:0]        k_reg;
    logic [lcgsrc_pkg::COUNT_W-1:0]        k_next;
    logic [lcgsrc_pkg::WORD_W-1:0]         entropy_reg;
    logic [lcgsrc_pkg::WORD_W-1:0]         entropy_next;
    logic                                  out_valid_reg;
    logic                                  out_valid_next;
    logic [lcgsrc_pkg::WORD_W-1:0]         out_value_reg;
    logic [lcgsrc_pkg::WORD_W-1:0]         out_value_next;
    logic                                  out_last_reg;
    logic                                  out_last_next;

    lcgsrc_pkg::gen_cmd_t                  cmd;
    logic [lcgsrc_pkg::WORD_W-1:0]         word;
    logic                                  req_beat;
    logic [lcgsrc_pkg::COUNT_W-1:0]        n_sat;
    logic [lcgsrc_pkg::COUNT_W-1:0]        grp_end;
    logic [lcgsrc_pkg::COUNT_W-1:0]        k_inc;
    logic                                  in_group;
    logic [7:0]                            byte_val;
    logic [lcgsrc_pkg::WORD_W-1:0]         fold;
    logic [7:0]                            sym;
    logic [lcgsrc_pkg::WORD_W-1:0]         beat_value;
    logic                                  beat_last;
    logic                                  slot_free;

    lcgsrc_gen u_gen (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .word  (word)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign req_beat  = req.valid && req.ready;
    assign n_sat     = (req.count > lcgsrc_pkg::COUNT_W'(lcgsrc_pkg::MAX_RUN))
                     ? lcgsrc_pkg::COUNT_W'(lcgsrc_pkg::MAX_RUN) : req.count;

    // generator commands
    always_comb
    begin
        cmd      = '0;
        cmd.data = entropy_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_beat)
                begin
                    cmd.data = req.seed_value;
                    case (req.op)
                        lcgsrc_pkg::OP_LOAD: cmd.load = 1'b1;
                        lcgsrc_pkg::OP_XOR:  cmd.mix  = 1'b1;
                        default:             cmd.load = 1'b0;
                    endcase
                end
            end
            S_ADV:   cmd.adv = 1'b1;
            default: cmd.adv = 1'b0;
        endcase
    end

    // beat formatting from the current word
    assign grp_end  = {n_reg[lcgsrc_pkg::COUNT_W-1:2], 2'b00};
    assign in_group = (op_reg == lcgsrc_pkg::OP_BYTES) && (k_reg < grp_end);
    assign k_inc    = k_reg + 1'b1;
    assign byte_val = in_group ? 8'(word >> {k_reg[1:0], 3'b000}) : word[7:0];
    assign fold     = word + (word >> 8);
    assign sym      = lcgsrc_pkg::symbol(fold[5:0] ^ fold[21:16]);

    always_comb
    begin
        case (op_reg)
            lcgsrc_pkg::OP_BYTES: beat_value = {24'b0, byte_val};
            lcgsrc_pkg::OP_CHARS: beat_value = {24'b0, sym};
            default:              beat_value = word;
        endcase
    end

    assign beat_last = (op_reg == lcgsrc_pkg::OP_WORD) || (k_inc == n_reg);
    assign slot_free = !out_valid_reg || rsp.ready;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        entropy_next   = entropy_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_beat)
                begin
                    op_next      = lcgsrc_pkg::op_t'(req.op);
                    entropy_next = req.entropy;
                    k_next       = '0;
                    n_next       = n_sat;
                    case (req.op)
                        lcgsrc_pkg::OP_WORD:
                        begin
                            n_next     = lcgsrc_pkg::COUNT_W'(1);
                            state_next = S_ADV;
                        end
                        lcgsrc_pkg::OP_BYTES, lcgsrc_pkg::OP_CHARS:
                        begin
                            if (n_sat != '0)
                            begin
                                state_next = S_ADV;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_ADV:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = beat_value;
                    out_last_next  = beat_last;
                    k_next         = k_inc;
                    if (beat_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (in_group && (k_reg[1:0] != 2'b11))
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_ADV;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            op_reg        <= lcgsrc_pkg::OP_WORD;
            n_reg         <= '0;
            k_reg         <= '0;
            entropy_reg   <= '0;
            out_value_reg <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            op_reg        <= op_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            entropy_reg   <= entropy_next;
            out_value_reg <= out_value_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.value = out_value_reg;
    assign rsp.last  = out_last_reg;

    // checks
    a_adv_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADV) |=> (state_reg == S_EMIT))
        else $error("advance not followed by emit");

    a_run_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (k_reg < n_reg))
        else $error("beat index past run length");

    a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (req_beat && (req.op == lcgsrc_pkg::OP_WORD)) |=> (state_reg == S_ADV))
        else $error("word request did not start a run");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> ($stable(out_value_reg) && out_valid_reg))
        else $error("pending result overwritten");

endmodule

// ===== src/lcgsrc_gen.sv =====
// Generator state and advance counter with the shared multiply-add.
module lcgsrc_gen (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  lcgsrc_pkg::gen_cmd_t                  cmd,
    output logic [lcgsrc_pkg::WORD_W-1:0]         word
);

    logic [lcgsrc_pkg::WORD_W-1:0]    state_reg;
    logic [lcgsrc_pkg::WORD_W-1:0]    state_next;
    logic [lcgsrc_pkg::ADV_CNT_W-1:0] cnt_reg;
    logic [lcgsrc_pkg::ADV_CNT_W-1:0] cnt_next;
    logic [lcgsrc_pkg::ADV_CNT_W-1:0] cnt_inc;
    logic                             reseed;
    logic [lcgsrc_pkg::WORD_W-1:0]    mixed;
    logic [lcgsrc_pkg::WORD_W-1:0]    prod;

    // advance path: bump counter, fold in entropy on the period, multiply-add
    assign cnt_inc = cnt_reg + 1'b1;
    assign reseed  = (cnt_inc == lcgsrc_pkg::ADV_CNT_W'(lcgsrc_pkg::RESEED_PERIOD));
    assign mixed   = reseed ? (state_reg ^ cmd.data) : state_reg;
    assign prod    = mixed * lcgsrc_pkg::LCG_MUL;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        if (cmd.load)
        begin
            state_next = cmd.data;
        end
        else if (cmd.mix)
        begin
            state_next = state_reg ^ cmd.data;
        end
        else if (cmd.adv)
        begin
            state_next = prod + lcgsrc_pkg::LCG_ADD;
            cnt_next   = reseed ? '0 : cnt_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcgsrc_pkg::SEED_AT_RESET;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign word = state_reg;

endmodule

// ===== dv/tb_lcg_random_word_byte_char_source.sv =====
`timescale 1ns / 1ps

module tb_lcg_random_word_byte_char_source;

    localparam int CLK_PERIOD = 8;
    localparam int RANDOM_ITEMS = 500;
    localparam int QUIET_TAIL = 60;
    localparam int HOLD_AT_BEAT = 120;
    localparam int HOLD_CYCLES = 300;
    localparam int PAUSE_AT_ITEM = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int NUM_ROWS = 22;

    // package constants the predictor works with
    localparam logic [2:0]  OP_WORD       = lcgsrc_pkg::OP_WORD;
    localparam logic [2:0]  OP_BYTES      = lcgsrc_pkg::OP_BYTES;
    localparam logic [2:0]  OP_CHARS      = lcgsrc_pkg::OP_CHARS;
    localparam logic [2:0]  OP_LOAD       = lcgsrc_pkg::OP_LOAD;
    localparam logic [2:0]  OP_XOR        = lcgsrc_pkg::OP_XOR;
    localparam logic [31:0] LCG_MUL       = lcgsrc_pkg::LCG_MUL;
    localparam logic [31:0] LCG_ADD       = lcgsrc_pkg::LCG_ADD;
    localparam logic [31:0] SEED_AT_RESET = lcgsrc_pkg::SEED_AT_RESET;
    localparam int          RESEED_PERIOD = lcgsrc_pkg::RESEED_PERIOD;
    localparam int          MAX_RUN       = lcgsrc_pkg::MAX_RUN;

    // op codes the block ignores
    localparam logic [2:0] OP_SPARE5 = 3'd5;
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    // character alphabet, first symbol in the top byte
    localparam logic [511:0] CHARSET =
        "abcdefghijklmnopqrstuvwxyz1234567890ABCDEFGHIJKLMNOPQRSTUVWXYZ@#";

    typedef struct {
        logic [31:0] value;
        logic        last;
    } result_beat_t;

    typedef struct {
        logic [2:0]  op;
        logic [6:0]  count;
        logic [31:0] seed;
        logic [31:0] entropy;
        bit          typed;
        logic [31:0] word;
    } stim_row_t;

    logic clk;
    logic rst_n;

    lcgsrc_req_if req();
    lcgsrc_rsp_if rsp();

    lcg_random_word_byte_char_source dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // generator shadow state
    logic [31:0] gen_state;
    logic [4:0]  adv_count;

    result_beat_t expected_beats[$];
    result_beat_t run_beats[$];
    stim_row_t    stim_rows[NUM_ROWS];

    int unsigned fail_count;
    int unsigned req_beats;
    int unsigned beats_checked;
    int unsigned op_hits[8];
    bit          quiet;
    bit          hold_done;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // one generator advance, with the periodic entropy mix
    function automatic logic [31:0] draw_word(input logic [31:0] entropy);
        adv_count = adv_count + 5'd1;
        if (adv_count == RESEED_PERIOD)
        begin
            gen_state = gen_state ^ entropy;
            adv_count = '0;
        end
        gen_state = gen_state * LCG_MUL + LCG_ADD;
        return gen_state;
    endfunction

    // work out the result beats of one request into run_beats
    function automatic void predict_run(input logic [2:0] op, input logic [6:0] count,
                                        input logic [31:0] seed, input logic [31:0] entropy);
        int unsigned n;
        int unsigned k;
        logic [31:0] w;
        n = (count > MAX_RUN) ? MAX_RUN : count;
        k = 0;
        run_beats.delete();
        case (op)
            OP_WORD:
            begin
                run_beats.push_back('{draw_word(entropy), 1'b1});
            end
            OP_BYTES:
            begin
                for (int i = 0; i < n / 4; i++)
                begin
                    w = draw_word(entropy);
                    for (int b = 0; b < 4; b++)
                    begin
                        run_beats.push_back('{{24'd0, w[8*b +: 8]}, (k + 1 == n)});
                        k++;
                    end
                end
                for (int i = 0; i < n % 4; i++)
                begin
                    w = draw_word(entropy);
                    run_beats.push_back('{{24'd0, w[7:0]}, (k + 1 == n)});
                    k++;
                end
            end
            OP_CHARS:
            begin
                for (int i = 0; i < n; i++)
                begin
                    w = draw_word(entropy);
                    w = w + (w >> 8);
                    w = w ^ ((w >> 16) & 32'hff);
                    run_beats.push_back('{{24'd0, CHARSET[8*(63 - w[5:0]) +: 8]},
                                          (k + 1 == n)});
                    k++;
                end
            end
            OP_LOAD: gen_state = seed;
            OP_XOR:  gen_state = gen_state ^ seed;
            default: ;
        endcase
    endfunction

    // offer one request beat and record its expected results on acceptance
    task automatic send_request(input logic [2:0] op, input logic [6:0] count,
                                input logic [31:0] seed, input logic [31:0] entropy,
                                input bit typed, input logic [31:0] typed_word);
        @(negedge clk);
        req.valid      <= 1'b1;
        req.op         <= op;
        req.count      <= count;
        req.seed_value <= seed;
        req.entropy    <= entropy;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        predict_run(op, count, seed, entropy);
        if (typed)
            expected_beats.push_back('{typed_word, 1'b1});
        else
            foreach (run_beats[i])
                expected_beats.push_back(run_beats[i]);
        req_beats++;
        op_hits[op]++;
    endtask

    task automatic idle_request(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            req.valid <= 1'b0;
        end
    endtask

    // random request, mostly short runs
    task automatic send_random_request();
        logic [2:0] op;
        logic [6:0] count;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 28)
            op = OP_WORD;
        else if (pick < 53)
            op = OP_BYTES;
        else if (pick < 78)
            op = OP_CHARS;
        else if (pick < 86)
            op = OP_LOAD;
        else if (pick < 94)
            op = OP_XOR;
        else
        begin
            case ($urandom_range(0, 2))
                0:       op = OP_SPARE5;
                1:       op = OP_SPARE6;
                default: op = OP_SPARE7;
            endcase
        end
        pick = $urandom_range(0, 99);
        if (pick < 5)
            count = 7'd0;
        else if (pick < 70)
            count = 7'($urandom_range(1, 8));
        else if (pick < 90)
            count = 7'($urandom_range(9, 32));
        else if (pick < 97)
            count = 7'($urandom_range(33, 64));
        else
            count = 7'($urandom_range(65, 127));
        send_request(op, count, $urandom, $urandom, 1'b0, '0);
    endtask

    // result checker
    always @(posedge clk)
    begin : result_check
        result_beat_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            beats_checked++;
            if (expected_beats.size() == 0)
            begin
                $error("unexpected result beat: value=%h last=%b", rsp.value, rsp.last);
                fail_count++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (rsp.value !== want.value)
                begin
                    $error("value mismatch: expected %h, actual %h", want.value, rsp.value);
                    fail_count++;
                end
                if (rsp.last !== want.last)
                begin
                    $error("last mismatch: expected %b, actual %b", want.last, rsp.last);
                    fail_count++;
                end
            end
        end
    end

    // result side throttle: random bursts, calm stretches, one long hold
    initial
    begin : rsp_throttle
        int gap;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && req_beats >= HOLD_AT_BEAT)
            begin
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (!quiet && (req_beats / 40) % 3 != 2 && $urandom_range(0, 4) == 0)
            begin
                gap = $urandom_range(1, 4);
                rsp.ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // run limit
    initial
    begin : watchdog
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned useful;
        clk = 1'b0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.op = OP_WORD;
        req.count = '0;
        req.seed_value = '0;
        req.entropy = '0;
        gen_state = SEED_AT_RESET;
        adv_count = '0;
        fail_count = 0;
        req_beats = 0;
        beats_checked = 0;
        quiet = 1'b0;
        hold_done = 1'b0;
        foreach (op_hits[i])
            op_hits[i] = 0;

        // directed rows; known words typed in where obvious
        stim_rows[0]  = '{OP_WORD,   7'd1,   32'd0,        32'd0,        1'b1, 32'd87628868};
        stim_rows[1]  = '{OP_LOAD,   7'd0,   32'd0,        32'd0,        1'b0, 32'd0};
        stim_rows[2]  = '{OP_WORD,   7'd0,   32'd0,        32'hffffffff, 1'b1, 32'd1013904223};
        stim_rows[3]  = '{OP_LOAD,   7'd127, 32'hffffffff, 32'd0,        1'b0, 32'd0};
        stim_rows[4]  = '{OP_WORD,   7'd64,  32'd0,        32'd0,        1'b1, 32'd1012239698};
        stim_rows[5]  = '{OP_XOR,    7'd1,   32'ha5a5a5a5, 32'h5a5a5a5a, 1'b0, 32'd0};
        stim_rows[6]  = '{OP_BYTES,  7'd1,   32'd0,        32'h12345678, 1'b0, 32'd0};
        stim_rows[7]  = '{OP_BYTES,  7'd4,   32'd0,        32'h87654321, 1'b0, 32'd0};
        stim_rows[8]  = '{OP_BYTES,  7'd7,   32'd0,        32'hdeadbeef, 1'b0, 32'd0};
        stim_rows[9]  = '{OP_BYTES,  7'd64,  32'd0,        32'hffffffff, 1'b0, 32'd0};
        stim_rows[10] = '{OP_BYTES,  7'd127, 32'd0,        32'h0f0f0f0f, 1'b0, 32'd0};
        stim_rows[11] = '{OP_BYTES,  7'd0,   32'd0,        32'd0,        1'b0, 32'd0};
        stim_rows[12] = '{OP_CHARS,  7'd1,   32'd0,        32'h00000001, 1'b0, 32'd0};
        stim_rows[13] = '{OP_CHARS,  7'd64,  32'd0,        32'hcafef00d, 1'b0, 32'd0};
        stim_rows[14] = '{OP_CHARS,  7'd100, 32'd0,        32'h80000000, 1'b0, 32'd0};
        stim_rows[15] = '{OP_CHARS,  7'd0,   32'hffffffff, 32'hffffffff, 1'b0, 32'd0};
        stim_rows[16] = '{OP_SPARE5, 7'd5,   32'hffffffff, 32'hffffffff, 1'b0, 32'd0};
        stim_rows[17] = '{OP_SPARE6, 7'd127, 32'h13572468, 32'h0,        1'b0, 32'd0};
        stim_rows[18] = '{OP_SPARE7, 7'd64,  32'h0,        32'h24681357, 1'b0, 32'd0};
        stim_rows[19] = '{OP_WORD,   7'd127, 32'hffffffff, 32'hffffffff, 1'b0, 32'd0};
        stim_rows[20] = '{OP_LOAD,   7'd3,   32'h00000000, 32'h0,        1'b0, 32'd0};
        stim_rows[21] = '{OP_CHARS,  7'd20,  32'd0,        32'hdeadbeef, 1'b0, 32'd0};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (stim_rows[i])
            send_request(stim_rows[i].op, stim_rows[i].count, stim_rows[i].seed,
                         stim_rows[i].entropy, stim_rows[i].typed, stim_rows[i].word);

        // random part; ignored op codes do not count
        useful = 0;
        while (useful < RANDOM_ITEMS)
        begin
            quiet = (useful >= RANDOM_ITEMS - QUIET_TAIL);
            if (useful == PAUSE_AT_ITEM)
            begin
                idle_request(1);
                while (expected_beats.size() != 0)
                    @(posedge clk);
            end
            if (!quiet && (req_beats / 40) % 3 != 1 && $urandom_range(0, 3) == 0)
                idle_request($urandom_range(1, 4));
            send_random_request();
            if (req.op <= OP_XOR)
                useful++;
        end
        idle_request(1);

        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests: %0d word, %0d byte, %0d char, %0d load, %0d xor",
                 req_beats, op_hits[OP_WORD], op_hits[OP_BYTES], op_hits[OP_CHARS],
                 op_hits[OP_LOAD], op_hits[OP_XOR]);
        $display("%0d ignored op codes, %0d result beats checked, %0d mismatches",
                 op_hits[OP_SPARE5] + op_hits[OP_SPARE6] + op_hits[OP_SPARE7],
                 beats_checked, fail_count);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== lcg_random_word_byte_char_source.f =====
src/lcgsrc_pkg.sv
src/lcgsrc_if.sv
src/lcgsrc_gen.sv
src/lcg_random_word_byte_char_source.sv
dv/tb_lcg_random_word_byte_char_source.sv
